/* sv/snne_pkg.sv */
package snne_pkg;
    localparam int LenBits = 32;
    localparam logic [31:0] H0 = 32'h67452301;
    localparam logic [31:0] H1 = 32'hefcdab89;
    localparam logic [31:0] H2 = 32'h98badcfe;
    localparam logic [31:0] H3 = 32'h10325476;
    localparam logic [31:0] H4 = 32'hc3d2e1f0;

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } t_cmp_ctl;

    function automatic logic [7:0] sfx_byte(input logic [3:0] i);
        logic [7:0] r;
        case (i)
            4'd0: r = 8'h51;  4'd1: r = 8'h8d;  4'd2: r = 8'h64;  4'd3: r = 8'ha6;
            4'd4: r = 8'h35;  4'd5: r = 8'hde;  4'd6: r = 8'hd8;  4'd7: r = 8'hc1;
            4'd8: r = 8'he6;  4'd9: r = 8'hb0;  4'd10: r = 8'h39; 4'd11: r = 8'hb1;
            4'd12: r = 8'hc3; 4'd13: r = 8'he5; 4'd14: r = 8'h52; default: r = 8'h30;
        endcase
        return r;
    endfunction

    function automatic logic [6:0] alpha(input logic [5:0] s);
        logic [6:0] r;
        if (s < 6'd26) r = 7'd65 + {1'b0, s};
        else if (s < 6'd52) r = 7'd71 + {1'b0, s};
        else if (s < 6'd62) r = {1'b0, s} - 7'd4;
        else if (s == 6'd62) r = 7'd43;
        else r = 7'd45;
        return r;
    endfunction
endpackage

/* sv/snne_compress.sv */
module snne_compress (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_clear,
    input  logic [511:0] i_block,
    output logic        o_done,
    output logic [63:0] o_h01
);
    logic [31:0] r_h [5];
    logic [31:0] r_a, r_b, r_c, r_d, r_e;
    logic [31:0] r_w [16];
    logic [6:0]  r_rnd;
    logic        r_busy, r_done;
    logic [31:0] f, k, w, t, wn;
    logic [3:0]  idx;

    assign idx = r_rnd[3:0];
    always_comb begin
        wn = r_w[idx - 4'd3] ^ r_w[idx - 4'd8] ^ r_w[idx - 4'd14] ^ r_w[idx];
        wn = {wn[30:0], wn[31]};
        w = (r_rnd < 7'd16) ? r_w[idx] : wn;
        if (r_rnd < 7'd20) begin
            f = (r_b & r_c) | (~r_b & r_d); k = 32'h5a827999;
        end else if (r_rnd < 7'd40) begin
            f = r_b ^ r_c ^ r_d; k = 32'h6ed9eba1;
        end else if (r_rnd < 7'd60) begin
            f = (r_b & r_c) | (r_b & r_d) | (r_c & r_d); k = 32'h8f1bbcdc;
        end else begin
            f = r_b ^ r_c ^ r_d; k = 32'hca62c1d6;
        end
        t = {r_a[26:0], r_a[31:27]} + f + r_e + k + w;
    end

    always_ff @(posedge i_clk) begin
        r_done <= 1'b0;
        if (!i_rst_n || i_clear) begin
            r_h[0] <= snne_pkg::H0; r_h[1] <= snne_pkg::H1; r_h[2] <= snne_pkg::H2;
            r_h[3] <= snne_pkg::H3; r_h[4] <= snne_pkg::H4;
            r_busy <= 1'b0; r_rnd <= '0;
        end else if (i_start) begin
            for (int i = 0; i < 16; i++) r_w[i] <= i_block[511 - 32*i -: 32];
            r_a <= r_h[0]; r_b <= r_h[1]; r_c <= r_h[2]; r_d <= r_h[3]; r_e <= r_h[4];
            r_busy <= 1'b1; r_rnd <= '0;
        end else if (r_busy) begin
            if (r_rnd >= 7'd16) r_w[idx] <= wn;
            r_e <= r_d; r_d <= r_c; r_c <= {r_b[1:0], r_b[31:2]}; r_b <= r_a; r_a <= t;
            if (r_rnd == 7'd79) begin
                r_busy <= 1'b0;
                r_h[0] <= r_h[0] + t; r_h[1] <= r_h[1] + r_a;
                r_h[2] <= r_h[2] + {r_b[1:0], r_b[31:2]};
                r_h[3] <= r_h[3] + r_c; r_h[4] <= r_h[4] + r_d;
                r_done <= 1'b1;
            end
            r_rnd <= r_rnd + 7'd1;
        end
    end
    assign o_done = r_done;
    assign o_h01 = {r_h[0], r_h[1]};
endmodule

/* sv/symbol_name_nid_encoder_core.sv */
// Name bytes are taken one per item, back to back; the item that fills a 64-byte block starts
// 80 rounds of one shared SHA-1 round unit, one round a cycle, and ready stays low until they are done.
// On the item with tlast the 16 suffix bytes, the end marker and the zero padding are written
// one per cycle, pausing while a filled block runs, then the length; after the final block run
// the 11 characters stream out, one per accepted item.
// s_tdata: name_byte[7:0]; s_tuser: byte_present. m_tdata: id_char[6:0]; m_tuser: length_error.
module symbol_name_nid_encoder_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,  // name_byte
    input  logic       s_tuser,  // byte_present
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,  // id_char, pad bit
    output logic       m_tuser,  // length_error
    output logic       m_tlast
);
    typedef enum logic [2:0] {S_IN, S_SFX, S_PAD, S_LEN, S_WAIT, S_OUT} t_state;
    t_state r_state, r_ret;
    logic [31:0] r_blk [16];
    logic [511:0] blk;
    logic [snne_pkg::LenBits-1:0] r_cnt, r_lenb;
    logic [5:0]  r_pos;
    logic [3:0]  r_i;
    logic        r_ovf, r_start, r_clear;
    logic [63:0] val, h01;
    logic        done;
    logic [5:0]  sel;
    logic [63:0] bits;

    always_comb for (int i = 0; i < 16; i++) blk[511 - 32*i -: 32] = r_blk[i];

    snne_compress u_cmp (.i_clk, .i_rst_n, .i_start(r_start), .i_clear(r_clear),
        .i_block(blk), .o_done(done), .o_h01(h01));

    assign val = {h01[7:0], h01[15:8], h01[23:16], h01[31:24],
                  h01[39:32], h01[47:40], h01[55:48], h01[63:56]};
    assign sel = (r_i < 4'd10) ? 6'(val >> (7'd58 - 7'd6 * {3'd0, r_i})) : {val[3:0], 2'b00};
    assign bits = 64'(r_lenb) << 3;
    assign s_tready = (r_state == S_IN) && !r_start;
    assign m_tvalid = (r_state == S_OUT);
    assign m_tdata = {1'b0, snne_pkg::alpha(sel)};
    assign m_tuser = r_ovf;
    assign m_tlast = (r_i == 4'd10);

    always_ff @(posedge i_clk) begin
        r_start <= 1'b0;
        r_clear <= 1'b0;
        if (!i_rst_n) begin
            r_state <= S_IN; r_cnt <= '0; r_ovf <= 1'b0; r_i <= '0; r_ret <= S_IN;
            r_pos <= '0; r_lenb <= '0;
        end else begin
            case (r_state)
                S_IN: if (s_tvalid && s_tready) begin
                    if (s_tuser) begin
                        r_blk[r_cnt[5:2]][{~r_cnt[1:0], 3'b000} +: 8] <= s_tdata;
                        if (&r_cnt) r_ovf <= 1'b1;
                        r_cnt <= r_cnt + 1'b1;
                    end
                    r_i <= '0;
                    if (s_tuser && &r_cnt[5:0]) begin
                        r_start <= 1'b1; r_state <= S_WAIT;
                        r_ret <= s_tlast ? S_SFX : S_IN;
                    end else if (s_tlast) r_state <= S_SFX;
                end
                S_SFX: begin
                    r_blk[r_cnt[5:2]][{~r_cnt[1:0], 3'b000} +: 8] <= snne_pkg::sfx_byte(r_i);
                    if (&r_cnt) r_ovf <= 1'b1;
                    r_cnt <= r_cnt + 1'b1;
                    // one marks the end marker as still to be written
                    r_i <= (r_i == 4'd15) ? 4'd1 : r_i + 4'd1;
                    r_pos <= r_cnt[5:0] + 6'd1;
                    r_lenb <= r_cnt + 1'b1;
                    if (&r_cnt[5:0]) begin
                        r_start <= 1'b1; r_state <= S_WAIT;
                        r_ret <= (r_i == 4'd15) ? S_PAD : S_SFX;
                    end else if (r_i == 4'd15) r_state <= S_PAD;
                end
                S_PAD: begin
                    r_i <= '0;
                    if (r_i == 4'd1) begin
                        r_blk[r_pos[5:2]][{~r_pos[1:0], 3'b000} +: 8] <= 8'h80;
                        r_pos <= r_pos + 6'd1;
                        if (&r_pos) begin r_start <= 1'b1; r_state <= S_WAIT; r_ret <= S_PAD; end
                    end else if (r_pos == 6'd56) r_state <= S_LEN;
                    else begin
                        r_blk[r_pos[5:2]][{~r_pos[1:0], 3'b000} +: 8] <= 8'h00;
                        r_pos <= r_pos + 6'd1;
                        if (&r_pos) begin r_start <= 1'b1; r_state <= S_WAIT; r_ret <= S_PAD; end
                    end
                end
                S_LEN: begin
                    r_blk[14] <= bits[63:32];
                    r_blk[15] <= bits[31:0];
                    r_start <= 1'b1; r_state <= S_WAIT; r_ret <= S_OUT; r_i <= '0;
                end
                S_WAIT: if (done) r_state <= r_ret;
                S_OUT: if (m_tready) begin
                    r_i <= r_i + 4'd1;
                    if (r_i == 4'd10) begin
                        r_state <= S_IN; r_cnt <= '0; r_ovf <= 1'b0; r_clear <= 1'b1; r_i <= '0;
                    end
                end
                default: r_state <= S_IN;
            endcase
        end
    end

    a_out_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> r_i <= 4'd10) else $error("index");
    a_no_in_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_tready && m_tvalid)) else $error("overlap");
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_start |=> r_state == S_WAIT) else $error("start");
endmodule
